// ===== rtl/lrcf_pkg.sv =====
// Shared constants, types and table builders for the LED ring clock face renderer.
`default_nettype none

package lrcf_pkg;

    localparam int LRCF_RING_LEDS  = 60;
    localparam int LRCF_WHEEL_SPAN = (LRCF_RING_LEDS - 2) + 255 + 40 + 1;
    localparam int LRCF_WHEEL_AW   = $clog2(LRCF_WHEEL_SPAN);
    localparam int LRCF_G_SHIFT    = 20;
    localparam int LRCF_B_SHIFT    = 40;

    localparam logic [2:0] REG_RING_OFFSET = 3'd0;
    localparam logic [2:0] REG_COLOR_MODE  = 3'd1;
    localparam logic [2:0] REG_DIM_START   = 3'd2;
    localparam logic [2:0] REG_DIM_END     = 3'd3;
    localparam logic [2:0] REG_FULL_LEVEL  = 3'd4;
    localparam logic [2:0] REG_DIM_LEVEL   = 3'd5;

    localparam logic [1:0] MODE_STATIC_RAINBOW = 2'd1;
    localparam logic [1:0] MODE_MOVING_RAINBOW = 2'd2;

    localparam logic [5:0] RST_RING_OFFSET = 6'd0;
    localparam logic [1:0] RST_COLOR_MODE  = 2'd0;
    localparam logic [4:0] RST_DIM_START   = 5'd22;
    localparam logic [4:0] RST_DIM_END     = 5'd7;
    localparam logic [8:0] RST_FULL_LEVEL  = 9'd256;
    localparam logic [8:0] RST_DIM_LEVEL   = 9'd64;

    localparam logic [7:0] MARK_R = 8'hd8;
    localparam logic [7:0] MARK_G = 8'h6c;
    localparam logic [7:0] MIN_G  = 8'h20;
    localparam logic [7:0] HOUR_R = 8'hF0;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef logic [7:0] t_wheel_rom [LRCF_WHEEL_SPAN];

    function automatic logic [2:0] mod5(logic [5:0] v);
        logic [9:0] p;
        logic [3:0] q;
        p = 10'(v) * 10'd13;
        q = p[9:6];
        return 3'(v - 6'(q) * 6'd5);
    endfunction

    function automatic longint q62_mul(longint a, longint b);
        logic           neg;
        logic [63:0]    ua;
        logic [63:0]    ub;
        logic [127:0]   p;
        logic [63:0]    r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? (64'd0 - 64'(a)) : 64'(a);
        ub  = (b < 0) ? (64'd0 - 64'(b)) : 64'(b);
        p   = {64'd0, ua} * {64'd0, ub};
        r   = p[125:62];
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [7:0] wheel_level(longint s);
        longint q;
        longint w;
        longint v;
        q = s / 128;
        w = q * 127 + (longint'(1) << 62);
        v = (w < 0) ? 0 : (w >> 55);
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic t_wheel_rom build_wheel();
        t_wheel_rom     rom;
        longint         sn;
        longint         cs;
        longint         s1;
        longint         c1;
        longint         ns;
        longint         nc;
        longint unsigned term;
        sn   = 0;
        cs   = longint'(1) << 62;
        s1   = 0;
        c1   = longint'(1) << 62;
        term = longint'(1) << 62;
        for (int n = 1; n <= 24; n++) begin
            term = term / 64'(10 * n);
            case (n % 4)
                1:       s1 = s1 + longint'(term);
                2:       c1 = c1 - longint'(term);
                3:       s1 = s1 - longint'(term);
                default: c1 = c1 + longint'(term);
            endcase
        end
        for (int k = 0; k < LRCF_WHEEL_SPAN; k++) begin
            rom[k] = wheel_level(sn);
            ns = q62_mul(sn, c1) + q62_mul(cs, s1);
            nc = q62_mul(cs, c1) - q62_mul(sn, s1);
            sn = ns;
            cs = nc;
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lrcf_intf.sv =====
// Handshake interfaces for the time input and the LED colour output.
`default_nettype none

interface lrcf_time_if;
    logic       valid;
    logic       ready;
    logic [4:0] hour;
    logic [5:0] minute;

    modport source (output valid, output hour, output minute, input ready);
    modport sink   (input valid, input hour, input minute, output ready);
endinterface

interface lrcf_led_if;
    logic       valid;
    logic       ready;
    logic [5:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;

    modport source (output valid, output led_index, output red, output green,
                    output blue, output frame_end, input ready);
    modport sink   (input valid, input led_index, input red, input green,
                    input blue, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrcf_wheel_rom.sv =====
// Sine colour wheel ROM with channel offset, wrap and registered read.
`default_nettype none

module lrcf_wheel_rom (
    input  wire logic                              i_clk,
    input  wire logic [lrcf_pkg::LRCF_WHEEL_AW-1:0] i_k,
    input  wire logic [1:0]                        i_ch,
    output logic [7:0]                             o_data
);

    localparam lrcf_pkg::t_wheel_rom WHEEL = lrcf_pkg::build_wheel();

    logic [lrcf_pkg::LRCF_WHEEL_AW:0]   w_sum;
    logic [lrcf_pkg::LRCF_WHEEL_AW-1:0] w_addr;
    logic [7:0]                         r_data;

    always_comb begin
        case (i_ch)
            lrcf_pkg::CH_GREEN: w_sum = {1'b0, i_k} + (lrcf_pkg::LRCF_WHEEL_AW + 1)'(lrcf_pkg::LRCF_G_SHIFT);
            lrcf_pkg::CH_BLUE:  w_sum = {1'b0, i_k} + (lrcf_pkg::LRCF_WHEEL_AW + 1)'(lrcf_pkg::LRCF_B_SHIFT);
            default:            w_sum = {1'b0, i_k};
        endcase
        if (w_sum >= (lrcf_pkg::LRCF_WHEEL_AW + 1)'(lrcf_pkg::LRCF_WHEEL_SPAN)) begin
            w_addr = lrcf_pkg::LRCF_WHEEL_AW'(w_sum
                     - (lrcf_pkg::LRCF_WHEEL_AW + 1)'(lrcf_pkg::LRCF_WHEEL_SPAN));
        end else begin
            w_addr = w_sum[lrcf_pkg::LRCF_WHEEL_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= WHEEL[w_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/led_ring_clock_face_renderer.sv =====
// Top level: renders one clock face frame of ring LED colours per time update.
//
//  channel   dir  protocol          payload
//  i_time    in   valid/ready       hour[4:0], minute[5:0]
//  o_led     out  valid/ready       led_index[5:0], red, green, blue, frame_end
//  apb       in   psel/penable      paddr[4:0], pwdata[31:0] -> prdata[31:0]
//
//  Each LED goes through a classify state, then a wheel ROM read and a
//  multiply through the shared scaler for each of the three channels, then
//  an output state with the colour on o_led.
//  A frame covers all 60 LEDs, and no new time item is taken before the
//  frame is through.
//  i_time.ready is low from accept until the frame_end item is taken.
//  A stalled o_led holds the sequencer; reset is synchronous, active low.
`default_nettype none

module led_ring_clock_face_renderer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lrcf_time_if.sink        i_time,
    lrcf_led_if.source       o_led,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_READ,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        CLS_OFF,
        CLS_MARK,
        CLS_WHEEL,
        CLS_MIN,
        CLS_HOUR
    } t_cls;

    localparam int AW = lrcf_pkg::LRCF_WHEEL_AW;
    localparam logic [5:0] LAST_LED = 6'(lrcf_pkg::LRCF_RING_LEDS - 1);
    localparam logic [6:0] RING7    = 7'(lrcf_pkg::LRCF_RING_LEDS);

    logic [5:0] r_ring_offset;
    logic [1:0] r_color_mode;
    logic [4:0] r_dim_start;
    logic [4:0] r_dim_end;
    logic [8:0] r_full_level;
    logic [8:0] r_dim_level;

    t_state     r_state;
    t_cls       r_cls;
    logic       r_in_ready;
    logic       r_out_valid;
    logic       r_frame_end;
    logic [5:0] r_led;
    logic [1:0] r_ch;
    logic [3:0] r_hour;
    logic [5:0] r_minute;
    logic [8:0] r_level;
    logic [5:0] r_off;
    logic [5:0] r_fade_step;
    logic [5:0] r_fade_k;
    logic [7:0] r_phase;
    logic [AW-1:0] r_k;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;

    logic       w_cfg_wr;
    logic       w_in_acc;
    logic [5:0] n_minute;
    logic [4:0] n_hour5;
    logic [3:0] n_hour;
    logic [5:0] n_off;
    logic       n_dim;
    logic [5:0] n_i;
    logic [6:0] n_hpos;
    logic [6:0] n_mpos;
    logic [5:0] n_hled;
    logic [5:0] n_mled;
    t_cls       n_cls;
    logic [AW-1:0] n_k;
    logic [7:0] w_rom;
    logic [7:0] n_chan;
    logic [16:0] w_prod;
    logic [7:0] n_scaled;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_offset <= lrcf_pkg::RST_RING_OFFSET;
            r_color_mode  <= lrcf_pkg::RST_COLOR_MODE;
            r_dim_start   <= lrcf_pkg::RST_DIM_START;
            r_dim_end     <= lrcf_pkg::RST_DIM_END;
            r_full_level  <= lrcf_pkg::RST_FULL_LEVEL;
            r_dim_level   <= lrcf_pkg::RST_DIM_LEVEL;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                lrcf_pkg::REG_RING_OFFSET: r_ring_offset <= pwdata[5:0];
                lrcf_pkg::REG_COLOR_MODE:  r_color_mode  <= pwdata[1:0];
                lrcf_pkg::REG_DIM_START:   r_dim_start   <= pwdata[4:0];
                lrcf_pkg::REG_DIM_END:     r_dim_end     <= pwdata[4:0];
                lrcf_pkg::REG_FULL_LEVEL:  r_full_level  <= pwdata[8:0];
                lrcf_pkg::REG_DIM_LEVEL:   r_dim_level   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            lrcf_pkg::REG_RING_OFFSET: prdata = {26'd0, r_ring_offset};
            lrcf_pkg::REG_COLOR_MODE:  prdata = {30'd0, r_color_mode};
            lrcf_pkg::REG_DIM_START:   prdata = {27'd0, r_dim_start};
            lrcf_pkg::REG_DIM_END:     prdata = {27'd0, r_dim_end};
            lrcf_pkg::REG_FULL_LEVEL:  prdata = {23'd0, r_full_level};
            lrcf_pkg::REG_DIM_LEVEL:   prdata = {23'd0, r_dim_level};
            default:                   prdata = 32'd0;
        endcase
    end

    assign w_in_acc = i_time.valid && r_in_ready;

    // frame setup from the accepted time
    always_comb begin
        n_minute = (i_time.minute >= 6'(lrcf_pkg::LRCF_RING_LEDS)) ? 6'd0 : i_time.minute;
        n_hour5  = (i_time.hour >= 5'd12) ? (i_time.hour - 5'd12) : i_time.hour;
        n_hour   = (n_hour5 >= 5'd12) ? 4'd0 : n_hour5[3:0];
        n_off    = (r_ring_offset >= 6'(lrcf_pkg::LRCF_RING_LEDS))
                   ? (r_ring_offset - 6'(lrcf_pkg::LRCF_RING_LEDS)) : r_ring_offset;
        n_dim    = (i_time.hour >= r_dim_start) || (i_time.hour < r_dim_end);
    end

    // per-LED classification
    always_comb begin
        if (r_led >= r_off) begin
            n_i = r_led - r_off;
        end else begin
            n_i = 6'({1'b0, r_led} + RING7 - {1'b0, r_off});
        end
        n_hpos = {1'b0, r_hour, 2'b00} + {3'b000, r_hour} + {1'b0, r_off};
        n_mpos = {1'b0, r_minute} + {1'b0, r_off};
        n_hled = (n_hpos >= RING7) ? 6'(n_hpos - RING7) : n_hpos[5:0];
        n_mled = (n_mpos >= RING7) ? 6'(n_mpos - RING7) : n_mpos[5:0];
        if (r_led == n_hled) begin
            n_cls = CLS_HOUR;
        end else if (r_led == n_mled) begin
            n_cls = CLS_MIN;
        end else if ((n_i < r_minute) && (lrcf_pkg::mod5(r_led) != 3'd0)) begin
            n_cls = CLS_WHEEL;
        end else if (lrcf_pkg::mod5(n_i) == 3'd0) begin
            n_cls = CLS_MARK;
        end else begin
            n_cls = CLS_OFF;
        end
        case (r_color_mode)
            lrcf_pkg::MODE_STATIC_RAINBOW: n_k = AW'(n_i);
            lrcf_pkg::MODE_MOVING_RAINBOW: n_k = AW'(n_i) + AW'(r_phase);
            default:                       n_k = AW'(r_fade_k);
        endcase
    end

    lrcf_wheel_rom u_wheel (
        .i_clk  (i_clk),
        .i_k    (r_k),
        .i_ch   (r_ch),
        .o_data (w_rom)
    );

    // shared channel scaler
    always_comb begin
        case (r_cls)
            CLS_HOUR:  n_chan = (r_ch == lrcf_pkg::CH_RED) ? lrcf_pkg::HOUR_R : 8'd0;
            CLS_MIN:   n_chan = (r_ch == lrcf_pkg::CH_GREEN) ? lrcf_pkg::MIN_G : 8'd0;
            CLS_WHEEL: n_chan = w_rom;
            CLS_MARK: begin
                case (r_ch)
                    lrcf_pkg::CH_RED:   n_chan = lrcf_pkg::MARK_R;
                    lrcf_pkg::CH_GREEN: n_chan = lrcf_pkg::MARK_G;
                    default:            n_chan = 8'd0;
                endcase
            end
            default:   n_chan = 8'd0;
        endcase
        w_prod   = 17'(n_chan) * 17'(r_level);
        n_scaled = (w_prod[16:8] > 9'd255) ? 8'd255 : w_prod[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fade_step <= 6'd0;
            r_phase     <= 8'd0;
            r_led       <= 6'd0;
            r_ch        <= lrcf_pkg::CH_RED;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_in_ready  <= 1'b0;
                        r_minute    <= n_minute;
                        r_hour      <= n_hour;
                        r_off       <= n_off;
                        r_level     <= n_dim ? r_dim_level : r_full_level;
                        r_fade_k    <= r_fade_step;
                        r_fade_step <= (r_fade_step < 6'(lrcf_pkg::LRCF_RING_LEDS))
                                       ? (r_fade_step + 6'd1) : 6'd0;
                        r_phase     <= r_phase + 8'd1;
                        r_led       <= 6'd0;
                        r_state     <= ST_CLASS;
                    end else begin
                        r_in_ready  <= 1'b1;
                    end
                end
                ST_CLASS: begin
                    r_cls   <= n_cls;
                    r_k     <= n_k;
                    r_ch    <= lrcf_pkg::CH_RED;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    case (r_ch)
                        lrcf_pkg::CH_RED:   r_red   <= n_scaled;
                        lrcf_pkg::CH_GREEN: r_green <= n_scaled;
                        default:            r_blue  <= n_scaled;
                    endcase
                    if (r_ch == lrcf_pkg::CH_BLUE) begin
                        r_out_valid <= 1'b1;
                        r_frame_end <= (r_led == LAST_LED);
                        r_state     <= ST_OUT;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= ST_READ;
                    end
                end
                ST_OUT: begin
                    if (o_led.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_led == LAST_LED) begin
                            r_in_ready <= 1'b1;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_led   <= r_led + 6'd1;
                            r_state <= ST_CLASS;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_time.ready    = r_in_ready;
    assign o_led.valid     = r_out_valid;
    assign o_led.led_index = r_led;
    assign o_led.red       = r_red;
    assign o_led.green     = r_green;
    assign o_led.blue      = r_blue;
    assign o_led.frame_end = r_frame_end;

endmodule

`default_nettype wire

// ===== rtl/lrcf_checker.sv =====
// Port-level checks for the renderer, bound to the top level.
`default_nettype none

module lrcf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [5:0] i_led_index,
    input wire logic [7:0] i_red,
    input wire logic       i_frame_end
);

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while an LED item is pending");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after accept");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_frame_end == (i_led_index == 6'd59)))
        else $error("frame_end does not match the last LED");

    a_mid_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_frame_end) |=> !i_in_ready)
        else $error("input ready in the middle of a frame");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_led_index) && $stable(i_red)))
        else $error("stalled LED item changed");

endmodule

bind led_ring_clock_face_renderer lrcf_checker u_lrcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_time.valid),
    .i_in_ready  (i_time.ready),
    .i_out_valid (o_led.valid),
    .i_out_ready (o_led.ready),
    .i_led_index (o_led.led_index),
    .i_red       (o_led.red),
    .i_frame_end (o_led.frame_end)
);

`default_nettype wire

// ===== sim/tb_led_ring_clock_face_renderer.sv =====
// Self-checking testbench for the LED ring clock face renderer: frame prediction and compare.
`timescale 1ns / 1ps

module tb_led_ring_clock_face_renderer;

    localparam int RING_LEDS   = 60;
    localparam int WHEEL_LEN   = (RING_LEDS - 2) + 255 + 40 + 1;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 26;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam logic [1:0] MODE_FADE   = 2'd0;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic [7:0] FACE_AMBER_R  = 8'hd8;
    localparam logic [7:0] FACE_AMBER_G  = 8'h6c;
    localparam logic [7:0] FACE_MINUTE_G = 8'h20;
    localparam logic [7:0] FACE_HOUR_R   = 8'hF0;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
    } t_time_item;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_led_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lrcf_time_if time_bus ();
    lrcf_led_if  led_bus ();

    led_ring_clock_face_renderer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_time  (time_bus),
        .o_led   (led_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0] sine_wheel [WHEEL_LEN];

    logic [5:0] cfg_offset     = lrcf_pkg::RST_RING_OFFSET;
    logic [1:0] cfg_mode       = lrcf_pkg::RST_COLOR_MODE;
    logic [4:0] cfg_dim_start  = lrcf_pkg::RST_DIM_START;
    logic [4:0] cfg_dim_end    = lrcf_pkg::RST_DIM_END;
    logic [8:0] cfg_full_level = lrcf_pkg::RST_FULL_LEVEL;
    logic [8:0] cfg_dim_level  = lrcf_pkg::RST_DIM_LEVEL;
    logic [5:0] fade_pos       = 6'd0;
    logic [7:0] wheel_phase    = 8'd0;

    t_time_item  pend_times [$];
    t_led_item   led_expect [$];
    t_time_item  next_time;
    t_led_item   led_seen;
    t_led_item   led_want;
    int unsigned mismatch_count = 0;
    int unsigned idle_pct = 16;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint fx_mul(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p  = {64'd0, ua} * {64'd0, ub};
        r  = p[125:62];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [23:0] wheel_rgb(int k);
        return {sine_wheel[k % WHEEL_LEN], sine_wheel[(k + 20) % WHEEL_LEN],
                sine_wheel[(k + 40) % WHEEL_LEN]};
    endfunction

    function automatic logic [7:0] dim_chan(logic [7:0] c, int lvl);
        int v;
        v = (int'(c) * lvl) >> 8;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    task automatic render_face(input logic [4:0] hr, input logic [5:0] mn);
        logic [23:0] pix [RING_LEDS];
        logic [23:0] fade_rgb;
        int          raw;
        int          h;
        int          m;
        int          off;
        int          lvl;
        int          led;
        t_led_item   it;
        raw = hr;
        m   = mn;
        if (m >= RING_LEDS) m = 0;
        h = raw;
        if (h >= 12) begin
            h = h - 12;
            if (h >= 12) h = 0;
        end
        off = cfg_offset;
        fade_rgb    = wheel_rgb(fade_pos);
        fade_pos    = (fade_pos < 6'd60) ? fade_pos + 6'd1 : 6'd0;
        wheel_phase = wheel_phase + 8'd1;
        for (int i = 0; i < RING_LEDS; i++) pix[i] = 24'd0;
        for (int i = 0; i < RING_LEDS; i += 5)
            pix[(i + off) % RING_LEDS] = {FACE_AMBER_R, FACE_AMBER_G, 8'h00};
        for (int i = 0; i < m; i++) begin
            led = (i + off) % RING_LEDS;
            if (led % 5 != 0) begin
                case (cfg_mode)
                    lrcf_pkg::MODE_STATIC_RAINBOW: pix[led] = wheel_rgb(i);
                    lrcf_pkg::MODE_MOVING_RAINBOW:
                        pix[led] = wheel_rgb(i + int'(wheel_phase));
                    default:                       pix[led] = fade_rgb;
                endcase
            end
        end
        pix[(m + off) % RING_LEDS]     = {8'h00, FACE_MINUTE_G, 8'h00};
        pix[(h * 5 + off) % RING_LEDS] = {FACE_HOUR_R, 16'h0000};
        lvl = (raw >= int'(cfg_dim_start) || raw < int'(cfg_dim_end)) ?
              int'(cfg_dim_level) : int'(cfg_full_level);
        for (int i = 0; i < RING_LEDS; i++) begin
            it.led_index = 6'(i);
            it.red       = dim_chan(pix[i][23:16], lvl);
            it.green     = dim_chan(pix[i][15:8], lvl);
            it.blue      = dim_chan(pix[i][7:0], lvl);
            it.frame_end = (i == RING_LEDS - 1);
            led_expect.push_back(it);
        end
    endtask

    task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] data,
                            output logic [31:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] kept;
        logic [31:0] seen;
        logic        known;
        known = 1'b1;
        kept  = 32'd0;
        case (idx)
            lrcf_pkg::REG_RING_OFFSET: begin
                cfg_offset = val[5:0]; kept = 32'(val[5:0]);
            end
            lrcf_pkg::REG_COLOR_MODE: begin
                cfg_mode = val[1:0]; kept = 32'(val[1:0]);
            end
            lrcf_pkg::REG_DIM_START: begin
                cfg_dim_start = val[4:0]; kept = 32'(val[4:0]);
            end
            lrcf_pkg::REG_DIM_END: begin
                cfg_dim_end = val[4:0]; kept = 32'(val[4:0]);
            end
            lrcf_pkg::REG_FULL_LEVEL: begin
                cfg_full_level = val[8:0]; kept = 32'(val[8:0]);
            end
            lrcf_pkg::REG_DIM_LEVEL: begin
                cfg_dim_level = val[8:0]; kept = 32'(val[8:0]);
            end
            default: known = 1'b0;
        endcase
        apb_xfer(1'b1, idx, val, seen);
        if (known) begin
            apb_xfer(1'b0, idx, 32'd0, seen);
            if (seen !== kept) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("register %0d read back %h, expected %h", idx, seen, kept);
            end
        end
    endtask

    task automatic push_time(input logic [4:0] hr, input logic [5:0] mn);
        t_time_item t;
        t.hour   = hr;
        t.minute = mn;
        pend_times.push_back(t);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pend_times.size() != 0 || time_bus.valid || led_expect.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // sender: hold the item until taken, predict the frame on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            time_bus.valid <= 1'b0;
        end else begin
            if (time_bus.valid && time_bus.ready)
                render_face(time_bus.hour, time_bus.minute);
            if (!time_bus.valid || time_bus.ready) begin
                if (pend_times.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_time = pend_times.pop_front();
                    time_bus.valid  <= 1'b1;
                    time_bus.hour   <= next_time.hour;
                    time_bus.minute <= next_time.minute;
                end else begin
                    time_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each LED item with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            led_bus.ready <= 1'b0;
        end else begin
            if (led_bus.valid && led_bus.ready) begin
                led_seen = {led_bus.led_index, led_bus.red, led_bus.green, led_bus.blue,
                            led_bus.frame_end};
                if (led_expect.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("LED item with nothing expected: idx %0d rgb %h %h %h end %b",
                                 led_seen.led_index, led_seen.red, led_seen.green,
                                 led_seen.blue, led_seen.frame_end);
                end else begin
                    led_want = led_expect.pop_front();
                    if (led_seen !== led_want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("LED mismatch: expected idx %0d rgb %h %h %h end %b, %s",
                                     led_want.led_index, led_want.red, led_want.green,
                                     led_want.blue, led_want.frame_end,
                                     $sformatf("got idx %0d rgb %h %h %h end %b",
                                               led_seen.led_index, led_seen.red,
                                               led_seen.green, led_seen.blue,
                                               led_seen.frame_end));
                    end
                end
            end
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                led_bus.ready <= 1'b0;
            end else begin
                led_bus.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((time_bus.valid && time_bus.ready) || (led_bus.valid && led_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        longint          sn;
        longint          cs;
        longint          s1;
        longint          c1;
        longint          ns;
        longint          nc;
        longint          q;
        longint          w;
        longint unsigned term;

        // build the sine wheel by rotation in Q62
        sn   = 0;
        cs   = longint'(1) << 62;
        s1   = 0;
        c1   = longint'(1) << 62;
        term = longint'(1) << 62;
        for (int n = 1; n <= 24; n++) begin
            term = term / (10 * n);
            case (n % 4)
                1:       s1 = s1 + longint'(term);
                2:       c1 = c1 - longint'(term);
                3:       s1 = s1 - longint'(term);
                default: c1 = c1 + longint'(term);
            endcase
        end
        for (int k = 0; k < WHEEL_LEN; k++) begin
            q = sn / 128;
            w = q * 127 + (longint'(1) << 62);
            w = (w < 0) ? 0 : (w >> 55);
            sine_wheel[k] = (w > 255) ? 8'd255 : 8'(w);
            ns = fx_mul(sn, c1) + fx_mul(cs, s1);
            nc = fx_mul(cs, c1) - fx_mul(sn, s1);
            sn = ns;
            cs = nc;
        end

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 5'd0;
        pwdata          = 32'd0;
        time_bus.valid  = 1'b0;
        time_bus.hour   = 5'd0;
        time_bus.minute = 6'd0;
        led_bus.ready   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // reset settings: extremes, minute wrap, hour reduction, dim boundaries
        push_time(5'd0, 6'd0);
        push_time(5'd31, 6'd63);
        push_time(5'd12, 6'd59);
        push_time(5'd23, 6'd60);
        push_time(5'd24, 6'd1);
        push_time(5'd11, 6'd30);
        push_time(5'd7, 6'd15);
        push_time(5'd21, 6'd42);
        push_time(5'd22, 6'd5);
        push_time(5'd6, 6'd58);
        wait_drained();

        cfg_write(lrcf_pkg::REG_RING_OFFSET, 32'd63);
        cfg_write(lrcf_pkg::REG_COLOR_MODE, 32'(MODE_SPARE));
        cfg_write(lrcf_pkg::REG_DIM_START, 32'd31);
        cfg_write(lrcf_pkg::REG_DIM_END, 32'd0);
        cfg_write(lrcf_pkg::REG_FULL_LEVEL, 32'd511);
        cfg_write(lrcf_pkg::REG_DIM_LEVEL, 32'd0);
        push_time(5'd15, 6'd44);
        push_time(5'd3, 6'd21);
        push_time(5'd30, 6'd10);
        push_time(5'd16, 6'd63);
        wait_drained();

        cfg_write(lrcf_pkg::REG_RING_OFFSET, 32'd60);
        cfg_write(lrcf_pkg::REG_COLOR_MODE, 32'(lrcf_pkg::MODE_STATIC_RAINBOW));
        cfg_write(lrcf_pkg::REG_DIM_START, 32'd0);
        cfg_write(lrcf_pkg::REG_DIM_END, 32'd31);
        cfg_write(lrcf_pkg::REG_FULL_LEVEL, 32'd300);
        cfg_write(lrcf_pkg::REG_DIM_LEVEL, 32'd511);
        cfg_write(REG_SPARE_A, 32'hffff_ffff);
        cfg_write(REG_SPARE_B, 32'h0000_0005);
        push_time(5'd9, 6'd59);
        push_time(5'd28, 6'd33);
        push_time(5'd1, 6'd2);
        wait_drained();

        cfg_write(lrcf_pkg::REG_RING_OFFSET, 32'd29);
        cfg_write(lrcf_pkg::REG_COLOR_MODE, 32'(lrcf_pkg::MODE_MOVING_RAINBOW));
        cfg_write(lrcf_pkg::REG_DIM_START, 32'd12);
        cfg_write(lrcf_pkg::REG_DIM_END, 32'd12);
        cfg_write(lrcf_pkg::REG_FULL_LEVEL, 32'd128);
        cfg_write(lrcf_pkg::REG_DIM_LEVEL, 32'd256);
        push_time(5'd13, 6'd50);
        push_time(5'd20, 6'd37);
        push_time(5'd2, 6'd55);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                cfg_write(lrcf_pkg::REG_RING_OFFSET, 32'd0);
                cfg_write(lrcf_pkg::REG_COLOR_MODE, 32'(MODE_FADE));
                cfg_write(lrcf_pkg::REG_DIM_START, 32'd0);
                cfg_write(lrcf_pkg::REG_DIM_END, 32'd0);
                cfg_write(lrcf_pkg::REG_FULL_LEVEL, 32'd0);
                cfg_write(lrcf_pkg::REG_DIM_LEVEL, 32'd0);
            end else if (p == RAND_PHASES - 1) begin
                cfg_write(lrcf_pkg::REG_RING_OFFSET, 32'd63);
                cfg_write(lrcf_pkg::REG_COLOR_MODE, 32'(lrcf_pkg::MODE_MOVING_RAINBOW));
                cfg_write(lrcf_pkg::REG_DIM_START, 32'd31);
                cfg_write(lrcf_pkg::REG_DIM_END, 32'd31);
                cfg_write(lrcf_pkg::REG_FULL_LEVEL, 32'd511);
                cfg_write(lrcf_pkg::REG_DIM_LEVEL, 32'd511);
            end else begin
                cfg_write(lrcf_pkg::REG_RING_OFFSET, $urandom());
                cfg_write(lrcf_pkg::REG_COLOR_MODE, 32'(p % 4));
                cfg_write(lrcf_pkg::REG_DIM_START, $urandom());
                cfg_write(lrcf_pkg::REG_DIM_END, $urandom());
                cfg_write(lrcf_pkg::REG_FULL_LEVEL,
                          ($urandom_range(1)) ? 32'd256 : $urandom());
                cfg_write(lrcf_pkg::REG_DIM_LEVEL, $urandom());
            end
            idle_pct = (p == 2) ? 0 : 16;
            // stall the receiver while the sender keeps offering
            if (p == 4) hold_req++;
            for (int j = 0; j < PHASE_ITEMS; j++)
                push_time(5'($urandom_range(31)),
                          ($urandom_range(99) < 80) ? 6'($urandom_range(59))
                                                    : 6'($urandom_range(63)));
            wait_drained();
        end
        idle_pct = 16;

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
